[design/hex_element_shape_weights_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the hexahedral shape-weight block
// Each macro expands to a clocked concurrent assertion, or to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef HEX_ELEMENT_SHAPE_WEIGHTS_ASSERT_SVH
`define HEX_ELEMENT_SHAPE_WEIGHTS_ASSERT_SVH
`ifndef SYNTH
`define HESW_ASSERT(label, prop, msg) label: assert property (@(posedge clk_i) \
  disable iff (!rst_ni) (prop)) else $error(msg);
`define HESW_ASSERT_NEXT(label, ante, cons, msg) `HESW_ASSERT(label, (ante) |=> (cons), msg)
`else
`define HESW_ASSERT(label, prop, msg)
`define HESW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[design/hesw_pkg.sv]
// ----------------------------------------------------------------------------
// hesw_pkg
// Shared widths, the node selection table and the queue status type.
// ----------------------------------------------------------------------------
package hesw_pkg;

  localparam int unsigned FRAC_BITS_DEF   = 14;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned COORD_W         = 16;
  localparam int unsigned WEIGHT_W        = 16;
  localparam int unsigned IDX_W           = 5;
  localparam int unsigned NODES_8         = 8;
  localparam int unsigned NODES_27        = 27;
  localparam logic [IDX_W-1:0] LAST_8     = IDX_W'(NODES_8 - 1);
  localparam logic [IDX_W-1:0] LAST_27    = IDX_W'(NODES_27 - 1);

  // Which 1D basis of one axis a node uses: low end, middle, high end.
  typedef enum logic [1:0] {
    SEL_L = 2'd0,
    SEL_M = 2'd1,
    SEL_H = 2'd2
  } basis_sel_e;

  typedef struct packed {
    basis_sel_e x;
    basis_sel_e y;
    basis_sel_e z;
  } node_sel_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Width of one 1D basis value. Covers coordinates over the whole 16-bit range.
  function automatic int unsigned basis_w(input int unsigned frac);
    return ((frac > 15) ? frac : (30 - frac)) + 3;
  endfunction

  function automatic node_sel_t node_sel(input logic [IDX_W-1:0] k);
    node_sel_t s;
    case (k)
      5'd0:    s = '{SEL_L, SEL_L, SEL_L};
      5'd1:    s = '{SEL_H, SEL_L, SEL_L};
      5'd2:    s = '{SEL_H, SEL_H, SEL_L};
      5'd3:    s = '{SEL_L, SEL_H, SEL_L};
      5'd4:    s = '{SEL_L, SEL_L, SEL_H};
      5'd5:    s = '{SEL_H, SEL_L, SEL_H};
      5'd6:    s = '{SEL_H, SEL_H, SEL_H};
      5'd7:    s = '{SEL_L, SEL_H, SEL_H};
      5'd8:    s = '{SEL_M, SEL_L, SEL_L};
      5'd9:    s = '{SEL_H, SEL_M, SEL_L};
      5'd10:   s = '{SEL_M, SEL_H, SEL_L};
      5'd11:   s = '{SEL_L, SEL_M, SEL_L};
      5'd12:   s = '{SEL_L, SEL_L, SEL_M};
      5'd13:   s = '{SEL_H, SEL_L, SEL_M};
      5'd14:   s = '{SEL_H, SEL_H, SEL_M};
      5'd15:   s = '{SEL_L, SEL_H, SEL_M};
      5'd16:   s = '{SEL_M, SEL_L, SEL_H};
      5'd17:   s = '{SEL_H, SEL_M, SEL_H};
      5'd18:   s = '{SEL_M, SEL_H, SEL_H};
      5'd19:   s = '{SEL_L, SEL_M, SEL_H};
      5'd20:   s = '{SEL_M, SEL_M, SEL_L};
      5'd21:   s = '{SEL_M, SEL_L, SEL_M};
      5'd22:   s = '{SEL_H, SEL_M, SEL_M};
      5'd23:   s = '{SEL_M, SEL_H, SEL_M};
      5'd24:   s = '{SEL_L, SEL_M, SEL_M};
      5'd25:   s = '{SEL_M, SEL_M, SEL_H};
      5'd26:   s = '{SEL_M, SEL_M, SEL_M};
      default: s = '{SEL_M, SEL_M, SEL_M};
    endcase
    return s;
  endfunction

endpackage

[design/hesw_point_if.sv]
// ----------------------------------------------------------------------------
// hesw_point_if
// Input channel: one reference point per word.
// ----------------------------------------------------------------------------
interface hesw_point_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hesw_pkg::COORD_W-1:0]  coord_xi;
  logic signed [hesw_pkg::COORD_W-1:0]  coord_eta;
  logic signed [hesw_pkg::COORD_W-1:0]  coord_zeta;

  modport source (output valid, output coord_xi, output coord_eta, output coord_zeta,
                  input ready);
  modport sink   (input valid, input coord_xi, input coord_eta, input coord_zeta,
                  output ready);
endinterface

[design/hesw_weight_if.sv]
// ----------------------------------------------------------------------------
// hesw_weight_if
// Output channel: one node weight per word.
// ----------------------------------------------------------------------------
interface hesw_weight_if;
  logic                                 valid;
  logic                                 ready;
  logic [hesw_pkg::IDX_W-1:0]           node_index;
  logic signed [hesw_pkg::WEIGHT_W-1:0] weight;
  logic                                 last_node;

  modport source (output valid, output node_index, output weight, output last_node,
                  input ready);
  modport sink   (input valid, input node_index, input weight, input last_node,
                  output ready);
endinterface

[design/hesw_queue.sv]
// ----------------------------------------------------------------------------
// hesw_queue
// Small FIFO of prepared basis sets between the front and the back.
// ----------------------------------------------------------------------------
`include "hex_element_shape_weights_assert.svh"

module hesw_queue #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = hesw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [WIDTH-1:0]      push_data_i,
  input  logic                  pop_i,
  output logic [WIDTH-1:0]      pop_data_o,
  output hesw_pkg::q_status_t   stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = slot_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == (PTR_W+1)'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  `HESW_ASSERT(a_no_overflow, push_i |-> !stat_o.full, "queue written while full")
  `HESW_ASSERT(a_no_underflow, pop_i |-> !stat_o.empty, "queue read while empty")

endmodule

[design/hesw_front.sv]
// ----------------------------------------------------------------------------
// hesw_front
// Takes points and builds the three 1D basis values of each axis.
// ----------------------------------------------------------------------------
module hesw_front #(
  parameter  int unsigned FRAC_BITS = hesw_pkg::FRAC_BITS_DEF,
  localparam int unsigned BW        = hesw_pkg::basis_w(FRAC_BITS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  hesw_point_if.sink                  point_i,
  input  logic                        quad_i,
  input  hesw_pkg::q_status_t         q_stat_i,
  output logic                        push_o,
  output logic                        quad_o,
  output logic [2:0][2:0][BW-1:0]     bases_o
);

  localparam int unsigned CW = hesw_pkg::COORD_W;
  localparam int unsigned AW = ((FRAC_BITS > CW - 1) ? FRAC_BITS : CW - 1) + 2;
  localparam int unsigned RW = 2 * AW;
  localparam logic signed [AW-1:0] ONE_A  = AW'(1) << FRAC_BITS;
  localparam logic signed [RW-1:0] ONE_SQ = RW'(1) << (2 * FRAC_BITS);

  logic                 s1_valid_q, s1_valid_d, s2_valid_q, s2_valid_d;
  logic                 s1_free, s2_free;
  logic signed [CW-1:0] s1_c_q [3];
  logic                 s1_quad_q, s2_quad_q;
  logic signed [AW-1:0] ce [3];
  logic signed [AW-1:0] cm [3];
  logic signed [AW-1:0] cn [3];
  logic signed [AW-1:0] cp [3];
  logic signed [RW-1:0] raw [3][3];
  logic signed [RW-1:0] s2_raw_q [3][3];

  // Round to nearest, ties away from zero, by FRAC_BITS or FRAC_BITS+1 bits.
  function automatic logic [BW-1:0] rnd(input logic signed [RW-1:0] v, input logic extra);
    logic signed [RW:0] t;
    logic [RW:0]        half;
    half = extra ? ((RW+1)'(1) << FRAC_BITS) : ((RW+1)'(1) << (FRAC_BITS - 1));
    t = {v[RW-1], v} + half - {{RW{1'b0}}, v[RW-1]};
    t = extra ? (t >>> (FRAC_BITS + 1)) : (t >>> FRAC_BITS);
    return t[BW-1:0];
  endfunction

  assign s2_free       = !s2_valid_q || !q_stat_i.full;
  assign s1_free       = !s1_valid_q || s2_free;
  assign point_i.ready = s1_free;
  assign push_o        = s2_valid_q && !q_stat_i.full;
  assign s1_valid_d    = s1_free ? point_i.valid : s1_valid_q;
  assign s2_valid_d    = s2_free ? s1_valid_q : s2_valid_q;

  // Raw products of the quadratic bases; the linear factors pass unrounded.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ce[a] = {{(AW-CW){s1_c_q[a][CW-1]}}, s1_c_q[a]};
      cm[a] = ce[a] - ONE_A;
      cn[a] = ONE_A - ce[a];
      cp[a] = ce[a] + ONE_A;
      if (s1_quad_q) begin
        raw[a][0] = ce[a] * cm[a];
        raw[a][1] = ONE_SQ - ce[a] * ce[a];
        raw[a][2] = ce[a] * cp[a];
      end else begin
        raw[a][0] = {{(RW-AW){cn[a][AW-1]}}, cn[a]};
        raw[a][1] = '0;
        raw[a][2] = {{(RW-AW){cp[a][AW-1]}}, cp[a]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && point_i.valid) begin
      s1_c_q[0] <= point_i.coord_xi;
      s1_c_q[1] <= point_i.coord_eta;
      s1_c_q[2] <= point_i.coord_zeta;
      s1_quad_q <= quad_i;
    end
    if (s2_free && s1_valid_q) begin
      s2_raw_q  <= raw;
      s2_quad_q <= s1_quad_q;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      bases_o[a][0] = s2_quad_q ? rnd(s2_raw_q[a][0], 1'b1) : s2_raw_q[a][0][BW-1:0];
      bases_o[a][1] = s2_quad_q ? rnd(s2_raw_q[a][1], 1'b0) : '0;
      bases_o[a][2] = s2_quad_q ? rnd(s2_raw_q[a][2], 1'b1) : s2_raw_q[a][2][BW-1:0];
    end
  end

  assign quad_o = s2_quad_q;

endmodule

[design/hesw_back.sv]
// ----------------------------------------------------------------------------
// hesw_back
// Walks the nodes of the head point and forms each weight in three stages.
// ----------------------------------------------------------------------------
`include "hex_element_shape_weights_assert.svh"

module hesw_back #(
  parameter  int unsigned FRAC_BITS = hesw_pkg::FRAC_BITS_DEF,
  localparam int unsigned BW        = hesw_pkg::basis_w(FRAC_BITS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [2:0][2:0][BW-1:0]     bases_i,
  input  logic                        quad_i,
  input  hesw_pkg::q_status_t         q_stat_i,
  output logic                        pop_o,
  hesw_weight_if.source               weight_o
);

  localparam int unsigned IW  = hesw_pkg::IDX_W;
  localparam int unsigned OW  = hesw_pkg::WEIGHT_W;
  localparam int unsigned PW  = 2 * BW - FRAC_BITS + 1;
  localparam int unsigned QW  = PW + BW;
  localparam int unsigned WW  = QW - FRAC_BITS + 1;
  localparam int WMAX_I = (FRAC_BITS >= OW - 1) ? 32767 : (1 << FRAC_BITS);
  localparam int WMIN_I = (FRAC_BITS >= OW - 1) ? -32768 : -(1 << FRAC_BITS);
  localparam logic signed [WW-1:0] W_MAX = WW'(WMAX_I);
  localparam logic signed [WW-1:0] W_MIN = WW'(WMIN_I);
  localparam logic signed [OW-1:0] O_MAX = OW'(WMAX_I);
  localparam logic signed [OW-1:0] O_MIN = OW'(WMIN_I);

  logic                   en, issue, issue_last;
  logic [IW-1:0]          cnt_q, cnt_d, last_idx;
  hesw_pkg::node_sel_t    sel;
  logic signed [BW-1:0]   bx, by, bz;

  logic                   a_valid_q, b_valid_q, out_valid_q;
  logic signed [2*BW-1:0] a_prod_q;
  logic signed [BW-1:0]   a_bz_q;
  logic                   a_quad_q, a_last_q, b_quad_q, b_last_q, out_last_q;
  logic [IW-1:0]          a_idx_q, b_idx_q, out_idx_q;
  logic signed [QW-1:0]   b_prod_q;
  logic signed [PW-1:0]   p;
  logic signed [WW-1:0]   w;
  logic signed [OW-1:0]   w_sat;
  logic signed [OW-1:0]   out_w_q;

  function automatic logic signed [PW-1:0] rnd_p(input logic signed [2*BW-1:0] v);
    logic signed [2*BW:0] t;
    t = {v[2*BW-1], v} + ((2*BW+1)'(1) << (FRAC_BITS - 1)) - {{(2*BW){1'b0}}, v[2*BW-1]};
    t = t >>> FRAC_BITS;
    return t[PW-1:0];
  endfunction

  // The 8-node weights fold in the factor 0.125 as three extra bits of shift.
  function automatic logic signed [WW-1:0] rnd_w(input logic signed [QW-1:0] v,
                                                 input logic quad);
    logic signed [QW:0] t;
    logic [QW:0]        half;
    half = quad ? ((QW+1)'(1) << (FRAC_BITS - 1)) : ((QW+1)'(1) << (FRAC_BITS + 2));
    t = {v[QW-1], v} + half - {{QW{1'b0}}, v[QW-1]};
    t = quad ? (t >>> FRAC_BITS) : (t >>> (FRAC_BITS + 3));
    return t[WW-1:0];
  endfunction

  // The whole back pipeline freezes while the output word waits.
  assign en         = !out_valid_q || weight_o.ready;
  assign issue      = en && !q_stat_i.empty;
  assign last_idx   = quad_i ? hesw_pkg::LAST_27 : hesw_pkg::LAST_8;
  assign issue_last = issue && (cnt_q == last_idx);
  assign pop_o      = issue_last;
  assign cnt_d      = issue ? (issue_last ? '0 : cnt_q + 1'b1) : cnt_q;

  assign sel = hesw_pkg::node_sel(cnt_q);
  assign bx  = $signed(bases_i[0][sel.x]);
  assign by  = $signed(bases_i[1][sel.y]);
  assign bz  = $signed(bases_i[2][sel.z]);

  assign p = rnd_p(a_prod_q);
  assign w = rnd_w(b_prod_q, b_quad_q);

  always_comb begin
    if (w > W_MAX) begin
      w_sat = O_MAX;
    end else if (w < W_MIN) begin
      w_sat = O_MIN;
    end else begin
      w_sat = w[OW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (en) begin
        a_valid_q   <= issue;
        b_valid_q   <= a_valid_q;
        out_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      a_prod_q <= bx * by;
      a_bz_q   <= bz;
      a_quad_q <= quad_i;
      a_idx_q  <= cnt_q;
      a_last_q <= issue_last;
    end
    if (en) begin
      b_prod_q   <= p * a_bz_q;
      b_quad_q   <= a_quad_q;
      b_idx_q    <= a_idx_q;
      b_last_q   <= a_last_q;
      out_w_q    <= w_sat;
      out_idx_q  <= b_idx_q;
      out_last_q <= b_last_q;
    end
  end

  assign weight_o.valid      = out_valid_q;
  assign weight_o.node_index = out_idx_q;
  assign weight_o.weight     = out_w_q;
  assign weight_o.last_node  = out_last_q;

  `HESW_ASSERT(a_cnt_idle,
               q_stat_i.empty |-> (cnt_q == '0),
               "node counter moved with no point")
  `HESW_ASSERT(a_cnt_mode,
               q_stat_i.empty || quad_i || (cnt_q <= hesw_pkg::LAST_8),
               "8-node count overrun")
  `HESW_ASSERT(a_last_idx,
               (out_valid_q && out_last_q) |->
                 ((out_idx_q == hesw_pkg::LAST_8) || (out_idx_q == hesw_pkg::LAST_27)),
               "last word on a wrong node")
  `HESW_ASSERT(a_w_range,
               out_valid_q |-> ((out_w_q <= O_MAX) && (out_w_q >= O_MIN)),
               "weight out of range")

endmodule

[design/hex_element_shape_weights.sv]
// ----------------------------------------------------------------------------
// hex_element_shape_weights
// Hexahedral shape-function weights (8-node trilinear or 27-node triquadratic).
// ----------------------------------------------------------------------------
//
//  channel    dir  words                                   handshake
//  point_i    in   coord_xi, coord_eta, coord_zeta         valid/ready
//  weight_o   out  node_index, weight, last_node           valid/ready
//  cfg        in   use_27_nodes (cfg_wdata_i)              cfg_we_i, no stall
//
//  A point yields 8 or 27 words, one per cycle from the node sequencer in the back
//  while the output accepts them. The first word of a point passes 2 front stages,
//  one queue slot and 3 back stages, the first front stage loading on the edge
//  that takes the point. The front and a 2-entry queue take further points while
//  the back is busy. Reset selects the 8-node element. A stalled output word
//  freezes the back; the front stalls only once the queue is full.
// ----------------------------------------------------------------------------
module hex_element_shape_weights #(
  parameter int unsigned FRAC_BITS   = hesw_pkg::FRAC_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = hesw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hesw_point_if.sink    point_i,
  hesw_weight_if.source weight_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i
);

  localparam int unsigned BW      = hesw_pkg::basis_w(FRAC_BITS);
  localparam int unsigned ENTRY_W = 9 * BW + 1;

  logic                      use27_q;
  logic                      push, pop, f_quad, b_quad;
  logic [2:0][2:0][BW-1:0]   f_bases, b_bases;
  logic [ENTRY_W-1:0]        head;
  hesw_pkg::q_status_t       q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use27_q <= 1'b0;
    end else if (cfg_we_i) begin
      use27_q <= cfg_wdata_i;
    end
  end

  hesw_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_i  (point_i),
    .quad_i   (use27_q),
    .q_stat_i (q_stat),
    .push_o   (push),
    .quad_o   (f_quad),
    .bases_o  (f_bases)
  );

  hesw_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({f_quad, f_bases}),
    .pop_i       (pop),
    .pop_data_o  (head),
    .stat_o      (q_stat)
  );

  assign b_quad  = head[ENTRY_W-1];
  assign b_bases = head[ENTRY_W-2:0];

  hesw_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bases_i  (b_bases),
    .quad_i   (b_quad),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .weight_o (weight_o)
  );

endmodule
